[design/hhfp_pkg.sv]
// Package for the HTTP header field parser: sizes, result kinds, parse modes
// and the command/status structs between controller and datapath.
// Depends on nothing; the controller, datapath and top level import it.
`timescale 1ns / 1ps

package hhfp_pkg;

  // Longest whitespace run that may be held inside a name or value.
  localparam int SpaceRunMax = 16;
  localparam int IdxW = (SpaceRunMax > 1) ? $clog2(SpaceRunMax) : 1;
  localparam int CntW = $clog2(SpaceRunMax + 1);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;

  localparam logic ActData    = 1'b0;
  localparam logic ActRestart = 1'b1;

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_FEND  = 3'd2,
    KIND_HEND  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [6:0] {
    MODE_LINE    = 7'b0000001,
    MODE_NAME    = 7'b0000010,
    MODE_VALUE   = 7'b0000100,
    MODE_CRVAL   = 7'b0001000,
    MODE_CRBLANK = 7'b0010000,
    MODE_DONE    = 7'b0100000,
    MODE_ERROR   = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic latch;       // capture the input transfer
    logic eval;        // decode the held byte and update parser state
    logic emit_flush;  // send the held whitespace byte at the read index
    logic emit_a;      // send the first planned result
    logic emit_b;      // send the second planned result
  } hhfp_cmd_t;

  typedef struct packed {
    logic plan_flush;  // decode wants held whitespace released
    logic plan_a;
    logic plan_b;
    logic a_q;         // registered plan
    logic b_q;
    logic flush_last;  // read index is at the final held byte
    logic slot_free;   // output register can take a result this cycle
  } hhfp_status_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChVt) || (b == ChFf);
  endfunction

endpackage

[design/hhfp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module hhfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/hhfp_ctrl.sv]
// Sequencing state machine for the header parser: takes an item, has the
// datapath decode it, then releases its results one per free output slot.
// Depends on hhfp_pkg.
`timescale 1ns / 1ps

module hhfp_ctrl
  import hhfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  hhfp_status_t st_i,
  output hhfp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_FLUSH  = 5'b00100,
    ST_ITEM_A = 5'b01000,
    ST_ITEM_B = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (st_i.plan_flush) begin
          state_d = ST_FLUSH;
        end else if (st_i.plan_a) begin
          state_d = ST_ITEM_A;
        end else if (st_i.plan_b) begin
          state_d = ST_ITEM_B;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (st_i.slot_free) begin
          cmd_o.emit_flush = 1'b1;
          if (st_i.flush_last) begin
            if (st_i.a_q) begin
              state_d = ST_ITEM_A;
            end else if (st_i.b_q) begin
              state_d = ST_ITEM_B;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_ITEM_A: begin
        if (st_i.slot_free) begin
          cmd_o.emit_a = 1'b1;
          state_d      = st_i.b_q ? ST_ITEM_B : ST_IDLE;
        end
      end
      ST_ITEM_B: begin
        if (st_i.slot_free) begin
          cmd_o.emit_b = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/hhfp_dp.sv]
// Datapath of the header parser: parser state, byte decode, the whitespace
// hold buffer (an hhfp_ram instance) and the output register.
// Depends on hhfp_pkg and hhfp_ram.
`timescale 1ns / 1ps

module hhfp_dp
  import hhfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         action_i,
  input  logic [7:0]   data_byte_i,
  input  hhfp_cmd_t    cmd_i,
  output hhfp_status_t st_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [2:0]   kind_o,
  output logic [7:0]   out_byte_o,
  output logic         last_o
);

  // Held input item.
  logic       action_q;
  logic [7:0] byte_q;

  // Parser state.
  mode_e           mode_q, mode_d;
  logic            field_open_q, field_open_d;
  logic            vhc_q, vhc_d;
  logic            fold_q, fold_d;
  logic [CntW-1:0] count_q, count_d;

  // Result plan of the current item: held bytes, then A, then B.
  logic [CntW-1:0] flush_n_q, flush_n_d;
  kind_e           flush_kind_q, flush_kind_d;
  logic            a_q, a_d, b_q, b_d;
  kind_e           a_kind_q, a_kind_d, b_kind_q, b_kind_d;
  logic [7:0]      a_byte_q, a_byte_d, b_byte_q, b_byte_d;

  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]      rdata;
  logic            hold_we;

  // Output register.
  logic       out_valid_q, out_valid_d;
  kind_e      out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  always_comb begin
    mode_d       = mode_q;
    field_open_d = field_open_q;
    vhc_d        = vhc_q;
    fold_d       = fold_q;
    count_d      = count_q;
    flush_n_d    = '0;
    flush_kind_d = KIND_NAME;
    a_d          = 1'b0;
    a_kind_d     = KIND_FEND;
    a_byte_d     = '0;
    b_d          = 1'b0;
    b_kind_d     = KIND_ERROR;
    b_byte_d     = '0;
    hold_we      = 1'b0;

    if (action_q == ActRestart) begin
      mode_d       = MODE_LINE;
      field_open_d = 1'b0;
      vhc_d        = 1'b0;
      fold_d       = 1'b0;
      count_d      = '0;
    end else begin
      case (mode_q)
        MODE_LINE: begin
          if (byte_q == ChCr) begin
            mode_d = MODE_CRBLANK;
          end else if (is_ws(byte_q)) begin
            if (!field_open_q) begin
              mode_d  = MODE_ERROR;
              count_d = '0;
              b_d     = 1'b1;
            end else begin
              mode_d  = MODE_VALUE;
              count_d = '0;
              if (vhc_q) begin
                fold_d = 1'b1;
              end
            end
          end else begin
            a_d          = field_open_q;
            field_open_d = 1'b1;
            vhc_d        = 1'b0;
            fold_d       = 1'b0;
            count_d      = '0;
            if (byte_q == ChColon) begin
              mode_d = MODE_VALUE;
            end else begin
              mode_d   = MODE_NAME;
              b_d      = 1'b1;
              b_kind_d = KIND_NAME;
              b_byte_d = byte_q;
            end
          end
        end
        MODE_NAME: begin
          if (byte_q == ChCr) begin
            mode_d  = MODE_ERROR;
            count_d = '0;
            b_d     = 1'b1;
          end else if (byte_q == ChColon) begin
            count_d = '0;
            mode_d  = MODE_VALUE;
            vhc_d   = 1'b0;
            fold_d  = 1'b0;
          end else if (is_ws(byte_q)) begin
            if (count_q >= CntW'(SpaceRunMax)) begin
              mode_d  = MODE_ERROR;
              count_d = '0;
              b_d     = 1'b1;
            end else begin
              hold_we = 1'b1;
              count_d = count_q + 1'b1;
            end
          end else begin
            flush_n_d    = count_q;
            flush_kind_d = KIND_NAME;
            count_d      = '0;
            b_d          = 1'b1;
            b_kind_d     = KIND_NAME;
            b_byte_d     = byte_q;
          end
        end
        MODE_VALUE: begin
          if (byte_q == ChCr) begin
            count_d = '0;
            mode_d  = MODE_CRVAL;
          end else if (is_ws(byte_q)) begin
            if (vhc_q && !fold_q) begin
              if (count_q >= CntW'(SpaceRunMax)) begin
                mode_d  = MODE_ERROR;
                count_d = '0;
                b_d     = 1'b1;
              end else begin
                hold_we = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
          end else begin
            if (fold_q) begin
              // A fold after content collapses to a single space.
              count_d  = '0;
              fold_d   = 1'b0;
              a_d      = 1'b1;
              a_kind_d = KIND_VALUE;
              a_byte_d = ChSpace;
            end else begin
              flush_n_d    = count_q;
              flush_kind_d = KIND_VALUE;
              count_d      = '0;
            end
            b_d      = 1'b1;
            b_kind_d = KIND_VALUE;
            b_byte_d = byte_q;
            vhc_d    = 1'b1;
          end
        end
        MODE_CRVAL: begin
          if (byte_q == ChLf) begin
            mode_d = MODE_LINE;
          end else begin
            mode_d  = MODE_ERROR;
            count_d = '0;
            b_d     = 1'b1;
          end
        end
        MODE_CRBLANK: begin
          if (byte_q == ChLf) begin
            a_d          = field_open_q;
            b_d          = 1'b1;
            b_kind_d     = KIND_HEND;
            field_open_d = 1'b0;
            vhc_d        = 1'b0;
            fold_d       = 1'b0;
            count_d      = '0;
            mode_d       = MODE_DONE;
          end else begin
            mode_d  = MODE_ERROR;
            count_d = '0;
            b_d     = 1'b1;
          end
        end
        default: begin
          // Finished or failed: bytes are ignored until restart.
        end
      endcase
    end
  end

  // The RAM reads the next index every cycle, so its data always matches
  // the registered read index.
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.eval) begin
      rd_idx_d = '0;
    end else if (cmd_i.emit_flush) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  hhfp_ram #(
    .Width(8),
    .Depth(SpaceRunMax)
  ) u_hold_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.eval && hold_we),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(byte_q),
    .raddr_i(rd_idx_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      byte_q   <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_LINE;
      field_open_q <= 1'b0;
      vhc_q        <= 1'b0;
      fold_q       <= 1'b0;
      count_q      <= '0;
      a_q          <= 1'b0;
      b_q          <= 1'b0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        mode_q       <= mode_d;
        field_open_q <= field_open_d;
        vhc_q        <= vhc_d;
        fold_q       <= fold_d;
        count_q      <= count_d;
        a_q          <= a_d;
        b_q          <= b_d;
      end
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      flush_n_q    <= flush_n_d;
      flush_kind_q <= flush_kind_d;
      a_kind_q     <= a_kind_d;
      a_byte_q     <= a_byte_d;
      b_kind_q     <= b_kind_d;
      b_byte_q     <= b_byte_d;
    end
    if (cmd_i.emit_flush) begin
      out_kind_q <= flush_kind_q;
      out_byte_q <= rdata;
      out_last_q <= st_o.flush_last && !a_q && !b_q;
    end else if (cmd_i.emit_a) begin
      out_kind_q <= a_kind_q;
      out_byte_q <= a_byte_q;
      out_last_q <= !b_q;
    end else if (cmd_i.emit_b) begin
      out_kind_q <= b_kind_q;
      out_byte_q <= b_byte_q;
      out_last_q <= 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_flush || cmd_i.emit_a || cmd_i.emit_b) begin
      out_valid_d = 1'b1;
    end
  end

  assign st_o.plan_flush = (flush_n_d != '0);
  assign st_o.plan_a     = a_d;
  assign st_o.plan_b     = b_d;
  assign st_o.a_q        = a_q;
  assign st_o.b_q        = b_q;
  assign st_o.flush_last = ((CntW'(rd_idx_q) + 1'b1) == flush_n_q);
  assign st_o.slot_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

[design/http_header_field_parser.sv]
// Top level of the HTTP header field parser: controller plus datapath.
// Depends on hhfp_pkg, hhfp_ctrl, hhfp_dp and hhfp_ram.
//
//   Transfer   Direction  Handshake               Payload
//   input      in         in_valid_i/in_ready_o   action_i, data_byte_i
//   result     out        out_valid_o/out_ready_i kind_o, out_byte_o, last_o
//
// One item at a time: a transfer in, a decode step, then the results it
// causes, one per free output slot. Held whitespace is released from the
// hold RAM one byte a cycle while the output slot is free.
// A stalled output holds the sequencer; the last result may wait in the
// output register while the next input is taken.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps

module http_header_field_parser
  import hhfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  hhfp_cmd_t    cmd;
  hhfp_status_t st;

  hhfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  hhfp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .action_i   (action_i),
    .data_byte_i(data_byte_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for http_header_field_parser: a directed table, then
// random header sections, all checked against a local parser prediction.
// Depends on hhfp_pkg and the http_header_field_parser design files.
`timescale 1ns / 1ps

module tb_top
  import hhfp_pkg::*;
();

  typedef enum logic [1:0] {
    CHK_PRED,  // checked only against the prediction
    CHK_NONE,  // the row must cause no result
    CHK_ONE    // the row must cause exactly the typed result
  } row_chk_e;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
    row_chk_e   chk;
    kind_e      kind;
    logic [7:0] obyte;
  } stim_row_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       fin;
  } parse_evt_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       action_i = ActData;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  http_header_field_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // Directed rows walk through each kind of result and each corner of the syntax.
  stim_row_t dir_rows [29] = '{
    '{ActRestart, 8'hFF,   CHK_NONE, KIND_NAME,  8'h00},
    // A continuation line with no field open is an error.
    '{ActData,    ChSpace, CHK_ONE,  KIND_ERROR, 8'h00},
    // Once in error, bytes are swallowed until restart.
    '{ActData,    8'h41,   CHK_NONE, KIND_NAME,  8'h00},
    '{ActRestart, 8'h00,   CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    8'hFF,   CHK_ONE,  KIND_NAME,  8'hFF},
    '{ActData,    ChTab,   CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    8'h00,   CHK_PRED, KIND_NAME,  8'h00},
    '{ActData,    ChSpace, CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChColon, CHK_NONE, KIND_NAME,  8'h00},
    // An LF that does not follow a CR is plain whitespace.
    '{ActData,    ChLf,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    8'h76,   CHK_ONE,  KIND_VALUE, 8'h76},
    '{ActData,    ChCr,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChLf,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChFf,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    8'h80,   CHK_PRED, KIND_NAME,  8'h00},
    '{ActData,    ChCr,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChLf,    CHK_NONE, KIND_NAME,  8'h00},
    // A line opening with a colon starts a field with an empty name.
    '{ActData,    ChColon, CHK_ONE,  KIND_FEND,  8'h00},
    '{ActData,    ChCr,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChLf,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChCr,    CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChLf,    CHK_PRED, KIND_NAME,  8'h00},
    '{ActData,    ChColon, CHK_NONE, KIND_NAME,  8'h00},
    '{ActRestart, 8'h00,   CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    8'h61,   CHK_ONE,  KIND_NAME,  8'h61},
    // A line without a colon fails at its CR.
    '{ActData,    ChCr,    CHK_ONE,  KIND_ERROR, 8'h00},
    '{ActRestart, 8'h00,   CHK_NONE, KIND_NAME,  8'h00},
    '{ActData,    ChCr,    CHK_NONE, KIND_NAME,  8'h00},
    // A CR followed by anything but LF fails on the following byte.
    '{ActData,    ChVt,    CHK_ONE,  KIND_ERROR, 8'h00}
  };

  stim_row_t  stim_rows [$];
  parse_evt_t step_evts [$];
  parse_evt_t parse_evts_due [$];
  int         forced_runs [$];

  // Local copy of the parser state.
  mode_e      pmode;
  logic       in_field;
  logic       val_seen;
  logic       fold_wait;
  logic [7:0] held_ws [SpaceRunMax];
  int         held_cnt;

  int n_errors = 0;
  int n_reported = 0;
  int n_results = 0;
  int taken_cnt = 0;
  int n_gen = 0;
  int kind_seen [5] = '{0, 0, 0, 0, 0};

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_period = 2;

  function automatic logic blank_byte(input logic [7:0] b);
    case (b)
      ChSpace, ChTab, ChLf, ChVt, ChFf: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_parser();
    pmode = MODE_LINE;
    in_field = 1'b0;
    val_seen = 1'b0;
    fold_wait = 1'b0;
    held_cnt = 0;
  endfunction

  function automatic void push_evt(input kind_e k, input logic [7:0] b);
    parse_evt_t e;
    e.kind = k;
    e.data = b;
    e.fin = 1'b0;
    step_evts.insert(step_evts.size(), e);
  endfunction

  function automatic void enter_error();
    pmode = MODE_ERROR;
    held_cnt = 0;
    push_evt(KIND_ERROR, 8'h00);
  endfunction

  function automatic void hold_blank(input logic [7:0] b);
    if (held_cnt >= SpaceRunMax) begin
      enter_error();
    end else begin
      held_ws[held_cnt] = b;
      held_cnt++;
    end
  endfunction

  function automatic void release_held(input kind_e k);
    for (int i = 0; i < held_cnt; i++) push_evt(k, held_ws[i]);
    held_cnt = 0;
  endfunction

  // Works out the results of one accepted item into step_evts.
  function automatic void parse_byte(input logic act, input logic [7:0] b);
    step_evts.delete();
    if (act == ActRestart) begin
      clear_parser();
    end else begin
      case (pmode)
        MODE_LINE: begin
          if (b == ChCr) begin
            pmode = MODE_CRBLANK;
          end else if (blank_byte(b)) begin
            if (!in_field) begin
              enter_error();
            end else begin
              pmode = MODE_VALUE;
              held_cnt = 0;
              if (val_seen) fold_wait = 1'b1;
            end
          end else begin
            if (in_field) push_evt(KIND_FEND, 8'h00);
            in_field = 1'b1;
            val_seen = 1'b0;
            fold_wait = 1'b0;
            held_cnt = 0;
            if (b == ChColon) begin
              pmode = MODE_VALUE;
            end else begin
              pmode = MODE_NAME;
              push_evt(KIND_NAME, b);
            end
          end
        end
        MODE_NAME: begin
          if (b == ChCr) begin
            enter_error();
          end else if (b == ChColon) begin
            held_cnt = 0;
            pmode = MODE_VALUE;
            val_seen = 1'b0;
            fold_wait = 1'b0;
          end else if (blank_byte(b)) begin
            hold_blank(b);
          end else begin
            release_held(KIND_NAME);
            push_evt(KIND_NAME, b);
          end
        end
        MODE_VALUE: begin
          if (b == ChCr) begin
            held_cnt = 0;
            pmode = MODE_CRVAL;
          end else if (blank_byte(b)) begin
            // Leading whitespace and whitespace after a fold are dropped outright.
            if (val_seen && !fold_wait) hold_blank(b);
          end else begin
            if (fold_wait) begin
              held_cnt = 0;
              fold_wait = 1'b0;
              push_evt(KIND_VALUE, ChSpace);
            end else begin
              release_held(KIND_VALUE);
            end
            push_evt(KIND_VALUE, b);
            val_seen = 1'b1;
          end
        end
        MODE_CRVAL: begin
          if (b == ChLf) pmode = MODE_LINE;
          else enter_error();
        end
        MODE_CRBLANK: begin
          if (b == ChLf) begin
            if (in_field) push_evt(KIND_FEND, 8'h00);
            push_evt(KIND_HEND, 8'h00);
            in_field = 1'b0;
            val_seen = 1'b0;
            fold_wait = 1'b0;
            held_cnt = 0;
            pmode = MODE_DONE;
          end else begin
            enter_error();
          end
        end
        default: ;
      endcase
    end
    if (step_evts.size() > 0) step_evts[step_evts.size() - 1].fin = 1'b1;
  endfunction

  function automatic void add_row(input logic act, input logic [7:0] b, input bit counts);
    stim_row_t r;
    r.act = act;
    r.data = b;
    r.chk = CHK_PRED;
    r.kind = KIND_NAME;
    r.obyte = 8'h00;
    stim_rows.insert(stim_rows.size(), r);
    if (counts) n_gen++;
  endfunction

  function automatic logic [7:0] pick_text(input bit allow_colon);
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 25));
    do begin
      b = 8'($urandom_range(0, 255));
    end while (blank_byte(b) || b == ChCr || (!allow_colon && b == ChColon));
    return b;
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 5))
      0, 1: return ChSpace;
      2: return ChTab;
      3: return ChLf;
      4: return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic void add_text(input int n, input bit allow_colon);
    for (int i = 0; i < n; i++) add_row(ActData, pick_text(allow_colon), 1'b1);
  endfunction

  function automatic void add_ws(input int n);
    for (int i = 0; i < n; i++) add_row(ActData, pick_ws(), 1'b1);
  endfunction

  // Inner whitespace runs are mostly short, now and then exactly full or one over.
  function automatic int ws_run_len();
    if (forced_runs.size() > 0) return forced_runs.pop_front();
    case ($urandom_range(0, 23))
      0: return SpaceRunMax;
      1: return SpaceRunMax + 1;
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic void add_crlf();
    add_row(ActData, ChCr, 1'b1);
    add_row(ActData, ChLf, 1'b1);
  endfunction

  function automatic void add_good_section();
    int parts;
    add_row(ActRestart, 8'($urandom_range(0, 255)), 1'b1);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 7) != 0) begin
        add_text($urandom_range(1, 3), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          add_ws(ws_run_len());
          add_text($urandom_range(1, 2), 1'b0);
        end
        add_ws($urandom_range(0, 2));
      end
      add_row(ActData, ChColon, 1'b1);
      add_ws($urandom_range(0, 2));
      for (int ln = 0; ln <= $urandom_range(0, 2); ln++) begin
        // Every line after the first is a folded continuation.
        if (ln > 0) add_ws($urandom_range(1, 2));
        parts = $urandom_range(0, 3);
        for (int p = 0; p < parts; p++) begin
          if (p > 0) add_ws(ws_run_len());
          add_text($urandom_range(1, 3), 1'b1);
        end
        add_ws($urandom_range(0, 2));
        add_crlf();
      end
    end
    add_crlf();
    // Bytes after the end of the headers are ignored by the parser.
    repeat ($urandom_range(0, 2)) add_row(ActData, 8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void add_broken_section();
    logic [7:0] b;
    add_row(ActRestart, 8'($urandom_range(0, 255)), 1'b1);
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1) == 0) begin
          add_text($urandom_range(1, 2), 1'b0);
          add_row(ActData, ChColon, 1'b1);
          add_text($urandom_range(0, 2), 1'b1);
        end
        add_row(ActData, ChCr, 1'b1);
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == ChLf);
        add_row(ActData, b, 1'b1);
      end
      1: begin
        add_text($urandom_range(1, 3), 1'b0);
        add_ws($urandom_range(0, 2));
        add_row(ActData, ChCr, 1'b1);
      end
      2: begin
        add_ws(1);
      end
      default: begin
        repeat ($urandom_range(6, 14)) add_row(ActData, 8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    repeat ($urandom_range(1, 3)) add_row(ActData, 8'($urandom_range(0, 255)), 1'b0);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(4_000_000);
    $display("%0t: timeout with %0d results still expected", $time, parse_evts_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: always ready, coin-toss ready, or ready only periodically, with a random period.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 80);
        rx_period = $urandom_range(2, 8);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
        RX_OPEN: out_ready_i <= 1'b1;
        RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= (rx_left % rx_period) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    stim_row_t  row;
    parse_evt_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        row = stim_rows[taken_cnt];
        taken_cnt++;
        parse_byte(action_i, data_byte_i);
        if ((row.chk == CHK_NONE && step_evts.size() != 0) ||
            (row.chk == CHK_ONE && (step_evts.size() != 1 || step_evts[0].kind != row.kind ||
                                    step_evts[0].data != row.obyte))) begin
          n_errors++;
          $display("%0t: row %0d: expected %0d result(s) kind %0d byte %02h, predicted %0d",
                   $time, taken_cnt - 1, (row.chk == CHK_ONE) ? 1 : 0, row.kind, row.obyte,
                   step_evts.size());
        end
        foreach (step_evts[i]) parse_evts_due.insert(parse_evts_due.size(), step_evts[i]);
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (kind_o <= KIND_ERROR) kind_seen[kind_o]++;
        if (parse_evts_due.size() == 0) begin
          n_errors++;
          if (n_reported < 50) begin
            n_reported++;
            $display("%0t: unexpected result: expected none, actual kind %0d byte %02h last %0b",
                     $time, kind_o, out_byte_o, last_o);
          end
        end else begin
          want = parse_evts_due.pop_front();
          if (kind_o !== want.kind || out_byte_o !== want.data || last_o !== want.fin) begin
            n_errors++;
            if (n_reported < 50) begin
              n_reported++;
              $display("%0t: expected kind %0d byte %02h last %0b, actual kind %0d byte %02h last %0b",
                       $time, want.kind, want.data, want.fin, kind_o, out_byte_o, last_o);
            end
          end
        end
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    clear_parser();
    foreach (dir_rows[i]) stim_rows.insert(stim_rows.size(), dir_rows[i]);
    // The first long runs are forced: one that just fits and one that overflows.
    forced_runs.insert(forced_runs.size(), SpaceRunMax);
    forced_runs.insert(forced_runs.size(), SpaceRunMax + 1);
    while (n_gen < 160) begin
      if ($urandom_range(0, 6) == 0) add_broken_section();
      else add_good_section();
    end

    wait (rst_ni);
    @(posedge clk_i);
    burst_left = 0;
    foreach (stim_rows[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      in_valid_i  <= 1'b1;
      action_i    <= stim_rows[i].act;
      data_byte_i <= stim_rows[i].data;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;

    while (parse_evts_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d items (%0d from the directed table), checked %0d results.",
             stim_rows.size(), $size(dir_rows), n_results);
    $display("Results: %0d name, %0d value, %0d field end, %0d headers end, %0d error.",
             kind_seen[KIND_NAME], kind_seen[KIND_VALUE], kind_seen[KIND_FEND],
             kind_seen[KIND_HEND], kind_seen[KIND_ERROR]);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/hhfp_pkg.sv
design/hhfp_ram.sv
design/hhfp_ctrl.sv
design/hhfp_dp.sv
design/http_header_field_parser.sv
tb/tb_top.sv
